>>> rtl/core/sirt_pkg.sv
package sirt_pkg;

    // Sizes of the alphabet, the digit stack and the division unit.
    localparam int MAX_RADIX     = 16;
    localparam int MAX_DIGITS    = 32;
    localparam int DIGIT_W       = 4;
    localparam int IDX_W         = 5;
    localparam int COUNT_W       = 6;
    localparam int RADIX_W       = 5;
    localparam int VALUE_W       = 32;
    localparam int BITS_PER_STEP = 8;
    localparam int STEP_W        = 2;

    // Characters with a special meaning.
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Configuration register indexes.
    localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] REG_ALPHA_LEN  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SIGN,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic alpha_ok;
        logic negative;
        logic quotient_zero;
        logic div_last;
        logic slot_free;
        logic last_digit;
    } status_t;

endpackage

>>> rtl/core/sirt_ctrl.sv
module sirt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sirt_pkg::status_t status,
    output sirt_pkg::cmd_t    cmd
);

    sirt_pkg::state_t state_reg;
    sirt_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sirt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new item is taken only while no item is in work.
    assign in_stall = (state_reg != sirt_pkg::ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            sirt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sirt_pkg::ST_CHECK;
                end
            end
            sirt_pkg::ST_CHECK:
            begin
                // An invalid alphabet drops the item without any output.
                if (!status.alpha_ok)
                begin
                    state_next = sirt_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.start = 1'b1;
                    if (status.negative)
                    begin
                        state_next = sirt_pkg::ST_SIGN;
                    end
                    else
                    begin
                        state_next = sirt_pkg::ST_DIV;
                    end
                end
            end
            sirt_pkg::ST_SIGN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = sirt_pkg::ST_DIV;
                end
            end
            sirt_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last && status.quotient_zero)
                begin
                    state_next = sirt_pkg::ST_EMIT;
                end
            end
            sirt_pkg::ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = sirt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sirt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/sirt_datapath.sv
module sirt_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sirt_pkg::VALUE_W-1:0]  value,
    input  logic [63:0]                   alphabet_low_chars,
    input  logic [63:0]                   alphabet_high_chars,
    input  logic [sirt_pkg::RADIX_W-1:0]  alphabet_length,
    input  sirt_pkg::cmd_t                cmd,
    output sirt_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    character,
    output logic                          last
);

    logic [7:0]                    chr [sirt_pkg::MAX_RADIX];
    logic                          alpha_ok;
    logic                          alpha_ok_reg;

    logic [sirt_pkg::VALUE_W-1:0]  raw_reg;
    logic [sirt_pkg::VALUE_W-1:0]  mag_reg;
    logic [sirt_pkg::VALUE_W-1:0]  mag_div;
    logic [sirt_pkg::RADIX_W-1:0]  rem_reg;
    logic [sirt_pkg::RADIX_W-1:0]  rem_div;
    logic [sirt_pkg::BITS_PER_STEP-1:0] quo_bits;
    logic [sirt_pkg::STEP_W-1:0]   step_reg;

    logic [sirt_pkg::DIGIT_W-1:0]  stack_reg [sirt_pkg::MAX_DIGITS];
    logic [sirt_pkg::COUNT_W-1:0]  count_reg;
    logic [sirt_pkg::COUNT_W-1:0]  count_m1;
    logic [sirt_pkg::IDX_W-1:0]    top_idx;
    logic [sirt_pkg::DIGIT_W-1:0]  top_digit;

    logic                          out_valid_reg;
    logic [7:0]                    char_reg;
    logic                          last_reg;

    // Split the alphabet registers into characters.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chr[i]     = alphabet_low_chars[8*i +: 8];
            chr[i + 8] = alphabet_high_chars[8*i +: 8];
        end
    end

    // Alphabet check: length 2 to 16, no sign characters, no repeats.
    always_comb
    begin
        alpha_ok = (alphabet_length > 5'd1) &&
                   (alphabet_length <= sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX));
        for (int i = 0; i < sirt_pkg::MAX_RADIX; i++)
        begin
            if (sirt_pkg::RADIX_W'(i) < alphabet_length)
            begin
                if ((chr[i] == sirt_pkg::CHAR_PLUS) || (chr[i] == sirt_pkg::CHAR_MINUS))
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < sirt_pkg::MAX_RADIX; j++)
                begin
                    if ((sirt_pkg::RADIX_W'(j) < alphabet_length) && (chr[i] == chr[j]))
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // One division step: eight bits of long division by the radix.
    always_comb
    begin
        rem_div  = rem_reg;
        quo_bits = '0;
        for (int k = 0; k < sirt_pkg::BITS_PER_STEP; k++)
        begin
            rem_div = {rem_div[sirt_pkg::RADIX_W-2:0], mag_reg[sirt_pkg::VALUE_W-1-k]};
            if (rem_div >= alphabet_length)
            begin
                rem_div = rem_div - alphabet_length;
                quo_bits[sirt_pkg::BITS_PER_STEP-1-k] = 1'b1;
            end
        end
        mag_div = {mag_reg[sirt_pkg::VALUE_W-sirt_pkg::BITS_PER_STEP-1:0], quo_bits};
    end

    // Top of the digit stack.
    assign count_m1  = count_reg - sirt_pkg::COUNT_W'(1);
    assign top_idx   = count_m1[sirt_pkg::IDX_W-1:0];
    assign top_digit = stack_reg[top_idx];

    // Status to the controller.
    assign status.alpha_ok      = alpha_ok_reg;
    assign status.negative      = raw_reg[sirt_pkg::VALUE_W-1];
    assign status.quotient_zero = (mag_div == '0);
    assign status.div_last      = (step_reg == '1);
    assign status.slot_free     = !out_valid_reg || !out_stall;
    assign status.last_digit    = (count_reg == sirt_pkg::COUNT_W'(1));

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_ok_reg  <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            alpha_ok_reg <= alpha_ok;

            if (cmd.start)
            begin
                step_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + sirt_pkg::STEP_W'(1);
                if ((step_reg == '1) && (count_reg < sirt_pkg::COUNT_W'(sirt_pkg::MAX_DIGITS)))
                begin
                    count_reg <= count_reg + sirt_pkg::COUNT_W'(1);
                end
            end
            else if (cmd.emit_digit)
            begin
                count_reg <= count_m1;
            end

            if (cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= value;
        end

        if (cmd.start)
        begin
            mag_reg <= raw_reg[sirt_pkg::VALUE_W-1] ? (~raw_reg + sirt_pkg::VALUE_W'(1))
                                                     : raw_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_div;
            if (step_reg == '1)
            begin
                // Push the remainder and start the next division afresh.
                rem_reg <= '0;
                if (count_reg < sirt_pkg::COUNT_W'(sirt_pkg::MAX_DIGITS))
                begin
                    stack_reg[count_reg[sirt_pkg::IDX_W-1:0]] <=
                        rem_div[sirt_pkg::DIGIT_W-1:0];
                end
            end
            else
            begin
                rem_reg <= rem_div;
            end
        end

        if (cmd.emit_sign)
        begin
            char_reg <= sirt_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= chr[top_digit];
            last_reg <= (count_reg == sirt_pkg::COUNT_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

>>> rtl/core/signed_integer_to_radix_text_top.sv
// Signed integer to radix text. Each item is a signed 32-bit value, written out as
// ASCII characters, one character per output item, in the radix given by the
// configured digit alphabet (registers at byte addresses 0, 8 and 16: characters
// 0 to 7, characters 8 to 15, and the alphabet length, which is the radix). A
// negative value is preceded by '-', digits come most significant first, and the
// final character carries last. An alphabet shorter than two characters, longer
// than sixteen, holding '+' or '-', or holding a repeated character, makes the
// block drop every item without output. One item at a time is in work: each digit
// is the remainder of a division of the magnitude by the radix in the shared
// long-division unit, which retires eight quotient bits per cycle, and the digits
// are then sent out. Radix 10 needs at most 10 digits, radix 2 up to 32.
module signed_integer_to_radix_text_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  character,
    output logic        last
);

    logic [63:0]                  alpha_low_reg;
    logic [63:0]                  alpha_high_reg;
    logic [sirt_pkg::RADIX_W-1:0] alpha_len_reg;
    logic [1:0]                   reg_index;
    sirt_pkg::cmd_t               cmd;
    sirt_pkg::status_t            status;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            alpha_len_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                sirt_pkg::REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                sirt_pkg::REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                sirt_pkg::REG_ALPHA_LEN:  alpha_len_reg  <= pwdata[sirt_pkg::RADIX_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            sirt_pkg::REG_ALPHA_LOW:  prdata = alpha_low_reg;
            sirt_pkg::REG_ALPHA_HIGH: prdata = alpha_high_reg;
            sirt_pkg::REG_ALPHA_LEN:  prdata = {{(64-sirt_pkg::RADIX_W){1'b0}}, alpha_len_reg};
            default:                  prdata = '0;
        endcase
    end

    sirt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sirt_datapath u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .value               (value),
        .alphabet_low_chars  (alpha_low_reg),
        .alphabet_high_chars (alpha_high_reg),
        .alphabet_length     (alpha_len_reg),
        .cmd                 (cmd),
        .status              (status),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .character           (character),
        .last                (last)
    );

endmodule

>>> test/signed_integer_to_radix_text_top_test.sv
module signed_integer_to_radix_text_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int END_LIMIT      = 2000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_VALUES  = 450;

    // One character of the text together with its end-of-text flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  character;
    logic        last;

    // Values waiting to be offered and characters still to come out.
    logic [31:0] pending_values[$];
    text_char_t  expected_text[$];

    // Copy of the alphabet registers as last written.
    logic [63:0] alpha_low_copy = '0;
    logic [63:0] alpha_high_copy = '0;
    logic [4:0]  alpha_len_copy = '0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  hold_left = 0;
    bit  item_taken = 1'b0;
    int  mismatch_count = 0;
    int  values_sent = 0;
    int  values_dropped = 0;
    int  chars_checked = 0;
    int  alphabets_loaded = 0;

    signed_integer_to_radix_text_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Character at a given position of the configured alphabet.
    function automatic logic [7:0] alphabet_char(logic [3:0] pos);
        logic [63:0] word;
        word = pos[3] ? alpha_high_copy : alpha_low_copy;
        return word[pos[2:0] * 8 +: 8];
    endfunction

    // An alphabet needs 2 to 16 distinct characters and no sign character.
    function automatic bit alphabet_usable();
        logic [7:0] c;
        if (alpha_len_copy <= 1 || alpha_len_copy > sirt_pkg::MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < alpha_len_copy; i++)
        begin
            c = alphabet_char(4'(i));
            if (c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < alpha_len_copy; j++)
                if (alphabet_char(4'(j)) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queues the characters that one value is written as.
    function automatic void predict_text(logic [31:0] v);
        logic [31:0] magnitude;
        logic [31:0] radix;
        logic [3:0]  digits[$];
        if (!alphabet_usable())
            return;
        radix = 32'(alpha_len_copy);
        magnitude = v;
        if (v[31])
        begin
            expected_text.push_back('{ch: sirt_pkg::CHAR_MINUS, last: 1'b0});
            magnitude = -v;
        end
        // Digits are found least significant first and queued in front, so they read most significant first.
        do
        begin
            digits.push_front(4'(magnitude % radix));
            magnitude = magnitude / radix;
        end
        while (magnitude != 0);
        for (int i = 0; i < digits.size(); i++)
            expected_text.push_back('{ch: alphabet_char(digits[i]),
                                      last: (i == digits.size() - 1)});
    endfunction

    // Picks a value: mostly random, with small numbers, extremes and radix powers.
    function automatic logic [31:0] pick_value();
        logic signed [31:0] v;
        logic [31:0]        radix;
        logic [31:0]        power;
        radix = (alpha_len_copy >= 2 && alpha_len_copy <= sirt_pkg::MAX_RADIX) ?
                32'(alpha_len_copy) : 10;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5:
            begin
                v = $urandom;
                v = v >>> $urandom_range(31);
            end
            6: v = $signed($urandom_range(2000)) - 1000;
            7:
            begin
                case ($urandom_range(4))
                    0: v = 0;
                    1: v = 1;
                    2: v = -1;
                    3: v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            default:
            begin
                power = 1;
                repeat ($urandom_range(1, 31))
                    if (power <= 32'h7FFF_FFFF / radix)
                        power = power * radix;
                v = power - $urandom_range(1);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Sampling side: predicts on every accepted value and checks every character.
    always @(posedge clk)
    begin
        item_taken = rst_n && in_valid && !in_stall;
        if (item_taken)
        begin
            values_sent++;
            if (!alphabet_usable())
                values_dropped++;
            predict_text(value);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_text.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected character %h last %b with nothing expected",
                         $time, character, last);
            end
            else
            begin
                if (character !== expected_text[0].ch)
                begin
                    mismatch_count++;
                    $display("%0t: character expected %h actual %h",
                             $time, expected_text[0].ch, character);
                end
                if (last !== expected_text[0].last)
                begin
                    mismatch_count++;
                    $display("%0t: last expected %b actual %b",
                             $time, expected_text[0].last, last);
                end
                void'(expected_text.pop_front());
                chars_checked++;
            end
        end
    end

    // Sender: offers the next pending value once the current one is taken.
    always @(negedge clk)
    begin
        if (!in_valid || item_taken)
        begin
            if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                value <= pending_values.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Ends the run when nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_register(logic [1:0] index, logic [63:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 3'b000};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (index)
            sirt_pkg::REG_ALPHA_LOW:  alpha_low_copy = data;
            sirt_pkg::REG_ALPHA_HIGH: alpha_high_copy = data;
            sirt_pkg::REG_ALPHA_LEN:  alpha_len_copy = data[4:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Waits for every value to be taken and every character to arrive, then
    // lets a possibly dropped value finish inside the block.
    task automatic wait_until_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_values.size() != 0 || in_valid || expected_text.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_alphabet(logic [63:0] low, logic [63:0] high, logic [63:0] len_word);
        wait_until_idle();
        write_register(sirt_pkg::REG_ALPHA_LOW, low);
        write_register(sirt_pkg::REG_ALPHA_HIGH, high);
        write_register(sirt_pkg::REG_ALPHA_LEN, len_word);
        alphabets_loaded++;
    endtask

    // Random alphabet of distinct characters, optionally broken on purpose.
    task automatic load_random_alphabet(bit make_invalid);
        logic [7:0]  chars[16];
        bit          used[256];
        int          len;
        int          j;
        int          k;
        logic [7:0]  c;
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] len_word;
        len = $urandom_range(2, 16);
        for (int i = 0; i < 16; i++)
        begin
            if (i < len)
            begin
                do c = 8'($urandom);
                while (c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS || used[c]);
                used[c] = 1'b1;
                chars[i] = c;
            end
            else
            begin
                chars[i] = 8'($urandom);
            end
        end
        if (make_invalid)
        begin
            case ($urandom_range(3))
                0: chars[$urandom_range(len - 1)] = sirt_pkg::CHAR_MINUS;
                1: chars[$urandom_range(len - 1)] = sirt_pkg::CHAR_PLUS;
                2:
                begin
                    j = $urandom_range(len - 1);
                    k = (j + 1 + $urandom_range(len - 2)) % len;
                    chars[k] = chars[j];
                end
                default: len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(17, 31);
            endcase
        end
        for (int i = 0; i < 8; i++)
        begin
            low[i * 8 +: 8] = chars[i];
            high[i * 8 +: 8] = chars[i + 8];
        end
        len_word = {$urandom, $urandom};
        len_word[4:0] = 5'(len);
        load_alphabet(low, high, len_word);
    endtask

    task automatic queue_random_values(int count);
        repeat (count)
            pending_values.push_back(pick_value());
    endtask

    // Idling pattern follows progress through the random values.
    task automatic pick_idle_pattern();
        int done;
        done = values_sent - values_dropped;
        if (done < TARGET_VALUES / 3)
        begin
            send_idle_pct = 26;
            recv_idle_pct = 50;
        end
        else if (done < 2 * TARGET_VALUES / 3)
        begin
            send_idle_pct = 50;
            recv_idle_pct = 26;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial
    begin
        int choice;
        send_idle_pct = 26;
        recv_idle_pct = 50;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Alphabet still at its reset length of zero: values are dropped.
        pending_values.push_back(32'd0);
        pending_values.push_back(32'h8000_0000);

        // Decimal, with sign characters and repeats in the unused positions.
        load_alphabet(64'h3736_3534_3332_3130, 64'h2D2B_2D2B_2D2B_3938, 64'd10);
        pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'd9, 32'd10, -32'd10};

        // Binary, the shortest alphabet: the most negative value gives 33 characters.
        load_alphabet(64'h3131_3030_3030_3130, 64'h2D2D_2D2D_2D2D_2D2D, 64'd2);
        pending_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};

        // Full sixteen-character alphabet.
        load_alphabet(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'd16);
        pending_values = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd255};

        // A zero byte inside the alphabet is an ordinary digit.
        load_alphabet(64'h0000_0000_0042_4100, 64'h0, 64'd3);
        pending_values = '{32'd0, 32'd5, -32'd4};

        // Invalid alphabets: too short, sign characters, a repeat, too long.
        load_alphabet(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'd1);
        pending_values.push_back(32'd7);
        load_alphabet(64'h3736_3534_3332_2D30, 64'h0, 64'd8);
        pending_values.push_back(32'd7);
        load_alphabet(64'h3736_3534_332B_3130, 64'h0, 64'd8);
        pending_values.push_back(-32'd7);
        load_alphabet(64'h3736_3534_3332_3130, 64'h3045_4443_4241_3938, 64'd16);
        pending_values.push_back(32'd7);
        load_alphabet(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'd17);
        pending_values.push_back(32'd7);
        load_alphabet(64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_values.push_back(32'd7);

        // Decimal while the receiver holds off long enough to back up the input.
        load_alphabet(64'h3736_3534_3332_3130, 64'h2D2B_2D2B_2D2B_3938, 64'd10);
        queue_random_values(20);
        hold_requests++;

        // Random part: mostly valid alphabets, now and then a broken one.
        while (values_sent - values_dropped < TARGET_VALUES)
        begin
            choice = $urandom_range(9);
            if (choice == 0)
                load_random_alphabet(1'b1);
            else if (choice == 1)
                load_alphabet(64'h3131_3030_3030_3130, {$urandom, $urandom}, 64'd2);
            else
                load_random_alphabet(1'b0);
            pick_idle_pattern();
            if (alphabet_usable())
                queue_random_values($urandom_range(8, 30));
            else
                queue_random_values(3);
        end

        // Drain: every value taken, then every character, then a quiet stretch.
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_values.size() != 0 || in_valid);
        for (int n = 0; n < END_LIMIT && expected_text.size() != 0; n++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d characters never arrived, next expected %h last %b",
                     $time, expected_text.size(), expected_text[0].ch, expected_text[0].last);
        end

        $display("Wrote %0d values (%0d dropped by a bad alphabet) under %0d alphabets,",
                 values_sent, values_dropped, alphabets_loaded);
        $display("checking %0d characters with %0d mismatches.", chars_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/core/sirt_pkg.sv
rtl/core/sirt_ctrl.sv
rtl/core/sirt_datapath.sv
rtl/core/signed_integer_to_radix_text_top.sv
test/signed_integer_to_radix_text_top_test.sv
